// ===== rtl/core/multi_pattern_string_matcher_core_macros.svh =====
// assertion helpers for the matcher core
`ifndef MULTI_PATTERN_STRING_MATCHER_CORE_MACROS_SVH
`define MULTI_PATTERN_STRING_MATCHER_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define MPSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define MPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mpsm_pkg.sv =====
`default_nettype none
package mpsm_pkg;

  localparam int unsigned CHAR_SPACE = 128;
  localparam int unsigned RESULT_CAP = 32;
  localparam int unsigned ID_W       = 5;
  localparam int unsigned POS_W      = 16;

  typedef enum logic [1:0] {
    FN_PATTERN = 2'd0,
    FN_BUILD   = 2'd1,
    FN_TEXT    = 2'd2,
    FN_RESTART = 2'd3
  } mpsm_func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NODES_FULL  = 3'd1,
    ST_SLOTS_FULL  = 3'd2,
    ST_TOO_LONG    = 3'd3,
    ST_ORDER       = 3'd4,
    ST_POS_OVF     = 3'd5
  } mpsm_status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_P_LOOK,
    S_P_END,
    S_EMIT,
    S_B_DEQ,
    S_B_AT,
    S_B_SL,
    S_B_RD1,
    S_B_RD2,
    S_B_ACT,
    S_B_OL,
    S_T_LOOK,
    S_T_NODE,
    S_T_SLOT,
    S_T_ID,
    S_T_PUSH,
    S_T_FLUSH
  } mpsm_state_e;

  typedef struct packed {
    logic             match_valid;
    logic [ID_W-1:0]  pattern_id;
    logic [POS_W-1:0] start_pos;
    logic             last_result;
    logic [2:0]       status;
  } mpsm_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mpsm_in_if.sv =====
`default_nettype none
interface mpsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] char_code;
  logic       pattern_last;

  modport source (output valid, output func, output char_code, output pattern_last,
                  input ready);
  modport sink (input valid, input func, input char_code, input pattern_last,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mpsm_out_if.sv =====
`default_nettype none
interface mpsm_out_if;
  logic        valid;
  logic        ready;
  logic        match_valid;
  logic [4:0]  pattern_id;
  logic [15:0] start_pos;
  logic        last_result;
  logic [2:0]  status;

  modport source (output valid, output match_valid, output pattern_id, output start_pos,
                  output last_result, output status, input ready);
  modport sink (input valid, input match_valid, input pattern_id, input start_pos,
                input last_result, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/multi_pattern_string_matcher_core.sv =====
// Aho-Corasick matcher core.
// in_i carries one command per beat: pattern char, build, text char or restart.
// out_o returns the results of each command, one beat per result; the final beat
// of a command has last_result set. A command with no match gives one beat with
// match_valid low. Results go through an output register, so a stalled receiver
// only holds the sequencer when it has a new beat to hand over.
// All tables sit in single-port-read memories driven by one sequencer, and every
// lookup is a registered read; in_i.ready is high only when idle.
// After reset a clearing pass writes zero through the goto memory and the suffix,
// output-link, depth and end-count tables; in_i.ready stays low meanwhile.
`default_nettype none
`include "multi_pattern_string_matcher_core_macros.svh"
module multi_pattern_string_matcher_core #(
  parameter int unsigned MAX_NODES    = 64,
  parameter int unsigned ALPHABET     = 128,
  parameter int unsigned MAX_DEPTH    = 16,
  parameter int unsigned MAX_PATTERNS = 32,
  parameter int unsigned END_SLOTS    = 2,
  parameter int unsigned POS_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpsm_in_if.sink    in_i,
  mpsm_out_if.source out_o
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned UW  = NW + 1;
  localparam int unsigned AW  = $clog2(ALPHABET);
  localparam int unsigned GAW = NW + AW;
  localparam int unsigned DW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CW  = $clog2(END_SLOTS + 1);
  localparam int unsigned SW  = (END_SLOTS > 1) ? $clog2(END_SLOTS) : 1;
  localparam int unsigned PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned PLW = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned TW  = POS_BITS + 1;
  localparam int unsigned XW  = (TW > mpsm_pkg::POS_W) ? TW : mpsm_pkg::POS_W;
  localparam int unsigned KW  = $clog2(mpsm_pkg::RESULT_CAP + 1);
  localparam int unsigned ND  = 1 << NW;

  // character folding table
  logic [AW-1:0] fold_tab [mpsm_pkg::CHAR_SPACE];
  for (genvar g = 0; g < mpsm_pkg::CHAR_SPACE; g++) begin : g_fold
    localparam int unsigned FoldVal = g % ALPHABET;
    assign fold_tab[g] = AW'(FoldVal);
  end

  mpsm_pkg::mpsm_state_e  state_q, state_d;
  mpsm_pkg::mpsm_status_e status_q, status_d;
  logic [GAW-1:0] clr_q, clr_d;
  logic [UW-1:0]  nodes_q, nodes_d;
  logic [PLW-1:0] pats_q, pats_d;
  logic [NW-1:0]  cur_q, cur_d;
  logic [DW-1:0]  len_q, len_d;
  logic           built_q, built_d;
  logic [NW-1:0]  match_q, match_d;
  logic [TW-1:0]  text_q, text_d;
  logic [UW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]  c_q, c_d;
  logic [UW-1:0]  guard_q, guard_d;
  logic [KW-1:0]  k_q, k_d;
  logic [CW-1:0]  j_q, j_d;
  logic           pend_v_q, pend_v_d;

  logic [AW-1:0]  ch_q, ch_d;
  logic           last_q, last_d;
  logic [NW-1:0]  at_q, at_d, sl_q, sl_d, nx_q, nx_d, s_q, s_d, n_q, n_d, next_q, next_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [mpsm_pkg::POS_W-1:0] pos_q, pos_d, pend_pos_q, pend_pos_d;
  logic [PW-1:0]  id_q, id_d, pend_id_q, pend_id_d;

  logic           go_we, go_re;
  logic [GAW-1:0] go_waddr, go_raddr;
  logic [NW-1:0]  go_wdata, go_rd;
  logic           sf_we, sf_re;
  logic [NW-1:0]  sf_waddr, sf_raddr, sf_wdata, sf_rd;
  logic           ol_we, ol_re;
  logic [NW-1:0]  ol_waddr, ol_raddr, ol_wdata, ol_rd;
  logic           dp_we, dp_re;
  logic [NW-1:0]  dp_waddr, dp_raddr;
  logic [DW-1:0]  dp_wdata, dp_rd;
  logic           ec_we, ec_re;
  logic [NW-1:0]  ec_waddr, ec_raddr;
  logic [CW-1:0]  ec_wdata, ec_rd;
  logic           ei_we, ei_re;
  logic [NW+SW-1:0] ei_waddr, ei_raddr;
  logic [PW-1:0]  ei_wdata, ei_rd;
  logic           qu_we, qu_re;
  logic [NW-1:0]  qu_waddr, qu_raddr, qu_wdata, qu_rd;

  logic                 push, can_push;
  mpsm_pkg::mpsm_beat_t beat;
  logic [XW-1:0]        pos_x;

  assign pos_x = XW'(text_q) + XW'(1) - XW'(dp_rd);

  always_comb begin
    state_d = state_q; status_d = status_q; clr_d = clr_q; nodes_d = nodes_q;
    pats_d = pats_q; cur_d = cur_q; len_d = len_q; built_d = built_q;
    match_d = match_q; text_d = text_q; head_d = head_q; tail_d = tail_q;
    c_d = c_q; guard_d = guard_q; k_d = k_q; j_d = j_q; pend_v_d = pend_v_q;
    ch_d = ch_q; last_d = last_q; at_d = at_q; sl_d = sl_q; nx_d = nx_q; s_d = s_q;
    n_d = n_q; next_d = next_q; cnt_d = cnt_q; pos_d = pos_q; pend_pos_d = pend_pos_q;
    id_d = id_q; pend_id_d = pend_id_q;
    go_we = 1'b0; go_waddr = '0; go_wdata = '0; go_re = 1'b0; go_raddr = '0;
    sf_we = 1'b0; sf_waddr = '0; sf_wdata = '0; sf_re = 1'b0; sf_raddr = '0;
    ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0; ol_re = 1'b0; ol_raddr = '0;
    dp_we = 1'b0; dp_waddr = '0; dp_wdata = '0; dp_re = 1'b0; dp_raddr = '0;
    ec_we = 1'b0; ec_waddr = '0; ec_wdata = '0; ec_re = 1'b0; ec_raddr = '0;
    ei_we = 1'b0; ei_waddr = '0; ei_wdata = '0; ei_re = 1'b0; ei_raddr = '0;
    qu_we = 1'b0; qu_waddr = '0; qu_wdata = '0; qu_re = 1'b0; qu_raddr = '0;
    push = 1'b0;
    beat = '0;
    in_i.ready = 1'b0;

    case (state_q)
      mpsm_pkg::S_CLEAR: begin
        go_we = 1'b1;
        go_waddr = clr_q;
        if (clr_q[GAW-1:NW] == '0) begin
          sf_we = 1'b1; sf_waddr = clr_q[NW-1:0];
          ol_we = 1'b1; ol_waddr = clr_q[NW-1:0];
          dp_we = 1'b1; dp_waddr = clr_q[NW-1:0];
          ec_we = 1'b1; ec_waddr = clr_q[NW-1:0];
        end
        clr_d = clr_q + GAW'(1);
        if (clr_q == '1) begin
          state_d = mpsm_pkg::S_IDLE;
        end
      end

      mpsm_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ch_d = fold_tab[in_i.char_code];
          last_d = in_i.pattern_last;
          status_d = mpsm_pkg::ST_OK;
          case (mpsm_pkg::mpsm_func_e'(in_i.func))
            mpsm_pkg::FN_PATTERN: begin
              if (built_q) begin
                status_d = mpsm_pkg::ST_ORDER;
                state_d = mpsm_pkg::S_EMIT;
              end else if (len_q >= DW'(MAX_DEPTH)) begin
                status_d = mpsm_pkg::ST_TOO_LONG;
                state_d = mpsm_pkg::S_P_END;
              end else begin
                go_re = 1'b1;
                go_raddr = {cur_q, fold_tab[in_i.char_code]};
                dp_re = 1'b1;
                dp_raddr = cur_q;
                state_d = mpsm_pkg::S_P_LOOK;
              end
            end
            mpsm_pkg::FN_BUILD: begin
              if (built_q) begin
                status_d = mpsm_pkg::ST_ORDER;
                state_d = mpsm_pkg::S_EMIT;
              end else begin
                qu_we = 1'b1;
                head_d = '0;
                tail_d = UW'(1);
                state_d = mpsm_pkg::S_B_DEQ;
              end
            end
            mpsm_pkg::FN_TEXT: begin
              if (!built_q) begin
                status_d = mpsm_pkg::ST_ORDER;
                state_d = mpsm_pkg::S_EMIT;
              end else if (text_q[POS_BITS]) begin
                status_d = mpsm_pkg::ST_POS_OVF;
                state_d = mpsm_pkg::S_EMIT;
              end else begin
                go_re = 1'b1;
                go_raddr = {match_q, fold_tab[in_i.char_code]};
                state_d = mpsm_pkg::S_T_LOOK;
              end
            end
            mpsm_pkg::FN_RESTART: begin
              match_d = '0;
              text_d = '0;
              state_d = mpsm_pkg::S_EMIT;
            end
            default: begin
              state_d = mpsm_pkg::S_EMIT;
            end
          endcase
        end
      end

      mpsm_pkg::S_P_LOOK: begin
        state_d = mpsm_pkg::S_P_END;
        if (go_rd == '0) begin
          if (nodes_q >= UW'(MAX_NODES)) begin
            status_d = mpsm_pkg::ST_NODES_FULL;
          end else begin
            go_we = 1'b1;
            go_waddr = {cur_q, ch_q};
            go_wdata = nodes_q[NW-1:0];
            dp_we = 1'b1;
            dp_waddr = nodes_q[NW-1:0];
            dp_wdata = dp_rd + DW'(1);
            nodes_d = nodes_q + UW'(1);
            cur_d = nodes_q[NW-1:0];
            len_d = len_q + DW'(1);
            ec_re = 1'b1;
            ec_raddr = nodes_q[NW-1:0];
          end
        end else begin
          cur_d = go_rd;
          len_d = len_q + DW'(1);
          ec_re = 1'b1;
          ec_raddr = go_rd;
        end
      end

      mpsm_pkg::S_P_END: begin
        if (last_q) begin
          if (status_q == mpsm_pkg::ST_OK) begin
            if (pats_q >= PLW'(MAX_PATTERNS) || ec_rd >= CW'(END_SLOTS)) begin
              status_d = mpsm_pkg::ST_SLOTS_FULL;
            end else begin
              ei_we = 1'b1;
              ei_waddr = {cur_q, ec_rd[SW-1:0]};
              ei_wdata = pats_q[PW-1:0];
              ec_we = 1'b1;
              ec_waddr = cur_q;
              ec_wdata = ec_rd + CW'(1);
              pats_d = pats_q + PLW'(1);
            end
          end
          cur_d = '0;
          len_d = '0;
        end
        state_d = mpsm_pkg::S_EMIT;
      end

      mpsm_pkg::S_EMIT: begin
        beat.last_result = 1'b1;
        beat.status = status_q;
        if (can_push) begin
          push = 1'b1;
          state_d = mpsm_pkg::S_IDLE;
        end
      end

      mpsm_pkg::S_B_DEQ: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          cur_d = '0;
          len_d = '0;
          status_d = mpsm_pkg::ST_OK;
          state_d = mpsm_pkg::S_EMIT;
        end else begin
          qu_re = 1'b1;
          qu_raddr = head_q[NW-1:0];
          head_d = head_q + UW'(1);
          state_d = mpsm_pkg::S_B_AT;
        end
      end

      mpsm_pkg::S_B_AT: begin
        at_d = qu_rd;
        sf_re = 1'b1;
        sf_raddr = qu_rd;
        state_d = mpsm_pkg::S_B_SL;
      end

      mpsm_pkg::S_B_SL: begin
        sl_d = sf_rd;
        c_d = '0;
        state_d = mpsm_pkg::S_B_RD1;
      end

      mpsm_pkg::S_B_RD1: begin
        go_re = 1'b1;
        go_raddr = {at_q, c_q};
        state_d = mpsm_pkg::S_B_RD2;
      end

      mpsm_pkg::S_B_RD2: begin
        nx_d = go_rd;
        go_re = 1'b1;
        go_raddr = {sl_q, c_q};
        state_d = mpsm_pkg::S_B_ACT;
      end

      mpsm_pkg::S_B_ACT: begin
        if (at_q == '0) begin
          if (nx_q != '0) begin
            sf_we = 1'b1; sf_waddr = nx_q;
            ol_we = 1'b1; ol_waddr = nx_q;
            if (tail_q < UW'(MAX_NODES)) begin
              qu_we = 1'b1;
              qu_waddr = tail_q[NW-1:0];
              qu_wdata = nx_q;
              tail_d = tail_q + UW'(1);
            end
          end
        end else if (nx_q == '0) begin
          go_we = 1'b1;
          go_waddr = {at_q, c_q};
          go_wdata = go_rd;
        end
        if (at_q != '0 && nx_q != '0) begin
          sf_we = 1'b1;
          sf_waddr = nx_q;
          sf_wdata = go_rd;
          s_d = go_rd;
          ec_re = 1'b1; ec_raddr = go_rd;
          ol_re = 1'b1; ol_raddr = go_rd;
          state_d = mpsm_pkg::S_B_OL;
        end else if (c_q == AW'(ALPHABET - 1)) begin
          state_d = mpsm_pkg::S_B_DEQ;
        end else begin
          c_d = c_q + AW'(1);
          state_d = mpsm_pkg::S_B_RD1;
        end
      end

      mpsm_pkg::S_B_OL: begin
        ol_we = 1'b1;
        ol_waddr = nx_q;
        ol_wdata = (ec_rd != '0) ? s_q : ol_rd;
        if (tail_q < UW'(MAX_NODES)) begin
          qu_we = 1'b1;
          qu_waddr = tail_q[NW-1:0];
          qu_wdata = nx_q;
          tail_d = tail_q + UW'(1);
        end
        if (c_q == AW'(ALPHABET - 1)) begin
          state_d = mpsm_pkg::S_B_DEQ;
        end else begin
          c_d = c_q + AW'(1);
          state_d = mpsm_pkg::S_B_RD1;
        end
      end

      mpsm_pkg::S_T_LOOK: begin
        n_d = go_rd;
        match_d = go_rd;
        k_d = '0;
        guard_d = '0;
        dp_re = 1'b1; dp_raddr = go_rd;
        ec_re = 1'b1; ec_raddr = go_rd;
        ol_re = 1'b1; ol_raddr = go_rd;
        state_d = mpsm_pkg::S_T_NODE;
      end

      mpsm_pkg::S_T_NODE: begin
        if (n_q == '0 || guard_q >= UW'(MAX_NODES) || k_q >= KW'(mpsm_pkg::RESULT_CAP)) begin
          text_d = text_q + TW'(1);
          status_d = mpsm_pkg::ST_OK;
          state_d = pend_v_q ? mpsm_pkg::S_T_FLUSH : mpsm_pkg::S_EMIT;
        end else begin
          cnt_d = ec_rd;
          next_d = ol_rd;
          pos_d = pos_x[mpsm_pkg::POS_W-1:0];
          j_d = '0;
          state_d = mpsm_pkg::S_T_SLOT;
        end
      end

      mpsm_pkg::S_T_SLOT: begin
        if (j_q < cnt_q && j_q < CW'(END_SLOTS) && k_q < KW'(mpsm_pkg::RESULT_CAP)) begin
          ei_re = 1'b1;
          ei_raddr = {n_q, j_q[SW-1:0]};
          state_d = mpsm_pkg::S_T_ID;
        end else begin
          n_d = next_q;
          guard_d = guard_q + UW'(1);
          dp_re = 1'b1; dp_raddr = next_q;
          ec_re = 1'b1; ec_raddr = next_q;
          ol_re = 1'b1; ol_raddr = next_q;
          state_d = mpsm_pkg::S_T_NODE;
        end
      end

      mpsm_pkg::S_T_ID: begin
        id_d = ei_rd;
        state_d = mpsm_pkg::S_T_PUSH;
      end

      mpsm_pkg::S_T_PUSH: begin
        beat.match_valid = 1'b1;
        beat.pattern_id = mpsm_pkg::ID_W'(pend_id_q);
        beat.start_pos = pend_pos_q;
        if (!pend_v_q || can_push) begin
          push = pend_v_q;
          pend_id_d = id_q;
          pend_pos_d = pos_q;
          pend_v_d = 1'b1;
          k_d = k_q + KW'(1);
          j_d = j_q + CW'(1);
          state_d = mpsm_pkg::S_T_SLOT;
        end
      end

      mpsm_pkg::S_T_FLUSH: begin
        beat.match_valid = 1'b1;
        beat.pattern_id = mpsm_pkg::ID_W'(pend_id_q);
        beat.start_pos = pend_pos_q;
        beat.last_result = 1'b1;
        if (can_push) begin
          push = 1'b1;
          pend_v_d = 1'b0;
          state_d = mpsm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mpsm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpsm_pkg::S_CLEAR;
      status_q <= mpsm_pkg::ST_OK;
      clr_q    <= '0;
      nodes_q  <= UW'(1);
      pats_q   <= '0;
      cur_q    <= '0;
      len_q    <= '0;
      built_q  <= 1'b0;
      match_q  <= '0;
      text_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      c_q      <= '0;
      guard_q  <= '0;
      k_q      <= '0;
      j_q      <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      clr_q    <= clr_d;
      nodes_q  <= nodes_d;
      pats_q   <= pats_d;
      cur_q    <= cur_d;
      len_q    <= len_d;
      built_q  <= built_d;
      match_q  <= match_d;
      text_q   <= text_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      c_q      <= c_d;
      guard_q  <= guard_d;
      k_q      <= k_d;
      j_q      <= j_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    last_q     <= last_d;
    at_q       <= at_d;
    sl_q       <= sl_d;
    nx_q       <= nx_d;
    s_q        <= s_d;
    n_q        <= n_d;
    next_q     <= next_d;
    cnt_q      <= cnt_d;
    pos_q      <= pos_d;
    pend_pos_q <= pend_pos_d;
    id_q       <= id_d;
    pend_id_q  <= pend_id_d;
  end

  mpsm_ram #(.WIDTH(NW), .DEPTH(1 << GAW)) u_goto (
    .clk_i, .we_i(go_we), .waddr_i(go_waddr), .wdata_i(go_wdata),
    .re_i(go_re), .raddr_i(go_raddr), .rdata_o(go_rd)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(ND)) u_suffix (
    .clk_i, .we_i(sf_we), .waddr_i(sf_waddr), .wdata_i(sf_wdata),
    .re_i(sf_re), .raddr_i(sf_raddr), .rdata_o(sf_rd)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(ND)) u_outlink (
    .clk_i, .we_i(ol_we), .waddr_i(ol_waddr), .wdata_i(ol_wdata),
    .re_i(ol_re), .raddr_i(ol_raddr), .rdata_o(ol_rd)
  );

  mpsm_ram #(.WIDTH(DW), .DEPTH(ND)) u_depth (
    .clk_i, .we_i(dp_we), .waddr_i(dp_waddr), .wdata_i(dp_wdata),
    .re_i(dp_re), .raddr_i(dp_raddr), .rdata_o(dp_rd)
  );

  mpsm_ram #(.WIDTH(CW), .DEPTH(ND)) u_endcnt (
    .clk_i, .we_i(ec_we), .waddr_i(ec_waddr), .wdata_i(ec_wdata),
    .re_i(ec_re), .raddr_i(ec_raddr), .rdata_o(ec_rd)
  );

  mpsm_ram #(.WIDTH(PW), .DEPTH(ND << SW)) u_endids (
    .clk_i, .we_i(ei_we), .waddr_i(ei_waddr), .wdata_i(ei_wdata),
    .re_i(ei_re), .raddr_i(ei_raddr), .rdata_o(ei_rd)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(ND)) u_queue (
    .clk_i, .we_i(qu_we), .waddr_i(qu_waddr), .wdata_i(qu_wdata),
    .re_i(qu_re), .raddr_i(qu_raddr), .rdata_o(qu_rd)
  );

  mpsm_outreg u_outreg (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .beat_i(beat),
    .can_push_o(can_push),
    .out_o(out_o)
  );

  `MPSM_ASSERT_IMP(a_nodes_bound, 1'b1, (nodes_q != '0) && (nodes_q <= UW'(MAX_NODES)), "node count out of range")
  `MPSM_ASSERT_IMP(a_queue_order, 1'b1, head_q <= tail_q, "bfs head passed tail")
  `MPSM_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "beat accepted while busy")
  `MPSM_ASSERT_IMP(a_push_room, push, can_push, "result pushed into a full output register")
  `MPSM_ASSERT_IMP(a_pend_in_walk, pend_v_q, (state_q == mpsm_pkg::S_T_NODE) || (state_q == mpsm_pkg::S_T_SLOT) || (state_q == mpsm_pkg::S_T_ID) || (state_q == mpsm_pkg::S_T_PUSH) || (state_q == mpsm_pkg::S_T_FLUSH), "pending match outside chain walk")

endmodule
`default_nettype wire

// ===== rtl/core/mpsm_ram.sv =====
`default_nettype none
module mpsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/mpsm_outreg.sv =====
`default_nettype none
module mpsm_outreg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mpsm_pkg::mpsm_beat_t beat_i,
  output logic                can_push_o,
  mpsm_out_if.source          out_o
);

  logic                 full_q, full_d;
  mpsm_pkg::mpsm_beat_t beat_q;

  assign can_push_o = !full_q || out_o.ready;

  always_comb begin
    full_d = full_q;
    if (push_i) begin
      full_d = 1'b1;
    end else if (out_o.ready) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_o.valid       = full_q;
  assign out_o.match_valid = beat_q.match_valid;
  assign out_o.pattern_id  = beat_q.pattern_id;
  assign out_o.start_pos   = beat_q.start_pos;
  assign out_o.last_result = beat_q.last_result;
  assign out_o.status      = beat_q.status;

endmodule
`default_nettype wire
